@@ rtl/tsa_pkg.sv @@
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared types, constants and the checksum fold for the SYN+ACK responder.
// ----------------------------------------------------------------------------
package tsa_pkg;

	localparam logic [15:0] HDR_LEN     = 16'd20;
	localparam logic [7:0]  PROTO_TCP   = 8'd6;
	localparam logic [7:0]  FLAG_SYN    = 8'h02;
	localparam logic [7:0]  FLAG_ACK    = 8'h10;
	localparam logic [7:0]  FLAGS_REPLY = FLAG_SYN | FLAG_ACK;
	localparam int          SYN_BIT     = 1;
	localparam int          ACK_BIT     = 4;
	localparam logic [15:0] IP_ID       = 16'h1234;
	localparam logic [7:0]  IP_TTL      = 8'd64;
	localparam logic [15:0] WINDOW      = 16'hFFFF;
	localparam logic [31:0] INIT_SEQ_RST = 32'h0000_1000;

	// fixed words of the reply headers, summed at elaboration
	localparam logic [19:0] IP_CONST  = 20'h4500 + 20'(2 * HDR_LEN) + 20'(IP_ID)
		+ 20'({IP_TTL, PROTO_TCP});
	localparam logic [19:0] TCP_CONST = 20'(PROTO_TCP) + 20'(HDR_LEN)
		+ 20'({4'(HDR_LEN / 4), 4'h0, FLAGS_REPLY}) + 20'(WINDOW);

	// configuration register indexes
	localparam logic CFG_OUR_MAC     = 1'b0;
	localparam logic CFG_INITIAL_SEQ = 1'b1;

	typedef enum logic [1:0] {
		KIND_SHORT   = 2'd0,
		KIND_ACK     = 2'd1,
		KIND_IGNORED = 2'd2,
		KIND_REPLY   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [47:0] peer_mac;
		logic [31:0] my_ip;
		logic [31:0] peer_ip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [31:0] init_seq;
		logic [31:0] ack;
	} hdr_t;

	// end-around carry fold of a 20-bit ones' complement sum, then invert
	function automatic logic [15:0] csum_fold(input logic [19:0] s);
		logic [16:0] f1;
		logic [16:0] f2;
		f1 = 17'(s[15:0]) + 17'(s[19:16]);
		f2 = 17'(f1[15:0]) + 17'(f1[16]);
		return ~f2[15:0];
	endfunction

endpackage

@@ rtl/tsa_front.sv @@
// ----------------------------------------------------------------------------
// tsa_front
// First stage: registers the segment fields, classifies it and forms the ack.
// ----------------------------------------------------------------------------
module tsa_front import tsa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] seg_len,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic [31:0] seq_num,
	input  logic [7:0]  flags,
	input  logic [31:0] src_ip,
	input  logic [31:0] dst_ip,
	input  logic [47:0] peer_mac,
	input  logic [31:0] init_seq,
	output logic        out_valid,
	input  logic        out_ready,
	output hdr_t        out_hdr
);

	logic  valid_s1;
	hdr_t  hdr_s1;
	kind_t kind;

	always_comb begin
		if (seg_len < HDR_LEN) begin
			kind = KIND_SHORT;
		end else if (flags[ACK_BIT] && !flags[SYN_BIT]) begin
			kind = KIND_ACK;
		end else if (!flags[SYN_BIT]) begin
			kind = KIND_IGNORED;
		end else begin
			kind = KIND_REPLY;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			hdr_s1.kind     <= kind;
			hdr_s1.peer_mac <= peer_mac;
			hdr_s1.my_ip    <= dst_ip;
			hdr_s1.peer_ip  <= src_ip;
			hdr_s1.sport    <= src_port;
			hdr_s1.dport    <= dst_port;
			hdr_s1.init_seq <= init_seq;
			hdr_s1.ack      <= seq_num + 32'd1;
		end
	end

	assign out_valid = valid_s1;
	assign out_hdr   = hdr_s1;

endmodule

@@ rtl/tsa_csum.sv @@
// ----------------------------------------------------------------------------
// tsa_csum
// Second and third stages: header word sums, then the IPv4 fold and the
// final TCP sum.
// ----------------------------------------------------------------------------
module tsa_csum import tsa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  hdr_t        in_hdr,
	output logic        out_valid,
	input  logic        out_ready,
	output hdr_t        out_hdr,
	output logic [15:0] ip_csum,
	output logic [19:0] tcp_sum
);

	logic        valid_s2;
	hdr_t        hdr_s2;
	logic [19:0] ip_sum_s2;
	logic [19:0] tcp_a_s2;
	logic [19:0] tcp_b_s2;
	logic        ready_s2;

	logic        valid_s3;
	hdr_t        hdr_s3;
	logic [15:0] ip_csum_s3;
	logic [19:0] tcp_sum_s3;
	logic        ready_s3;

	logic [19:0] addr_sum;

	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign in_ready = ready_s2;

	// both checksums cover the two addresses
	assign addr_sum = 20'(in_hdr.my_ip[31:16]) + 20'(in_hdr.my_ip[15:0])
		+ 20'(in_hdr.peer_ip[31:16]) + 20'(in_hdr.peer_ip[15:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= in_valid;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && in_valid) begin
			hdr_s2    <= in_hdr;
			ip_sum_s2 <= IP_CONST + addr_sum;
			tcp_a_s2  <= TCP_CONST + addr_sum;
			tcp_b_s2  <= 20'(in_hdr.sport) + 20'(in_hdr.dport)
				+ 20'(in_hdr.init_seq[31:16]) + 20'(in_hdr.init_seq[15:0])
				+ 20'(in_hdr.ack[31:16]) + 20'(in_hdr.ack[15:0]);
		end
		if (ready_s3 && valid_s2) begin
			hdr_s3     <= hdr_s2;
			ip_csum_s3 <= csum_fold(ip_sum_s2);
			tcp_sum_s3 <= tcp_a_s2 + tcp_b_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_hdr   = hdr_s3;
	assign ip_csum   = ip_csum_s3;
	assign tcp_sum   = tcp_sum_s3;

endmodule

@@ rtl/tcp_syn_ack_responder.sv @@
// ----------------------------------------------------------------------------
// tcp_syn_ack_responder
// Classifies a parsed TCP segment and builds SYN+ACK reply header fields with
// the IPv4 header checksum and the TCP checksum.
//
//   channel  handshake            content
//   in       in_valid/in_ready    parsed segment fields
//   out      out_valid/out_ready  kind and reply header fields
//   cfg      cfg_we              register index cfg_idx, data cfg_wdata
//
// Four register stages: capture and classify, word sums, IPv4 fold and TCP
// total, TCP fold and output register. One item enters per cycle unless
// back-pressure reaches the input. A stalled output holds each stage that
// is full; an empty stage still takes an item. Reset clears the valid bits
// and sets initial_seq to 0x1000.
// ----------------------------------------------------------------------------
module tcp_syn_ack_responder import tsa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [47:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] seg_len,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic [31:0] seq_num,
	input  logic [7:0]  flags,
	input  logic [31:0] src_ip,
	input  logic [31:0] dst_ip,
	input  logic [47:0] peer_mac,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [47:0] dest_mac,
	output logic [31:0] reply_ip_src,
	output logic [31:0] reply_ip_dst,
	output logic [15:0] ip_checksum,
	output logic [15:0] reply_src_port,
	output logic [15:0] reply_dst_port,
	output logic [31:0] reply_seq,
	output logic [31:0] reply_ack,
	output logic [7:0]  reply_flags,
	output logic [15:0] tcp_checksum
);

	logic [31:0] init_seq_q;

	logic        front_valid;
	logic        front_ready;
	hdr_t        front_hdr;

	logic        csum_valid;
	logic        csum_ready;
	hdr_t        csum_hdr;
	logic [15:0] csum_ip;
	logic [19:0] csum_tcp;

	logic        valid_s4;
	logic        reply;
	kind_t       kind_s4;
	logic [47:0] dest_mac_s4;
	logic [31:0] ip_src_s4;
	logic [31:0] ip_dst_s4;
	logic [15:0] ip_csum_s4;
	logic [15:0] sport_s4;
	logic [15:0] dport_s4;
	logic [31:0] seq_s4;
	logic [31:0] ack_s4;
	logic [7:0]  flags_s4;
	logic [15:0] tcp_csum_s4;

	// our_mac takes part in no result field, so its writes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_seq_q <= INIT_SEQ_RST;
		end else if (cfg_we && cfg_idx == CFG_INITIAL_SEQ) begin
			init_seq_q <= cfg_wdata[31:0];
		end
	end

	tsa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.seg_len   (seg_len),
		.src_port  (src_port),
		.dst_port  (dst_port),
		.seq_num   (seq_num),
		.flags     (flags),
		.src_ip    (src_ip),
		.dst_ip    (dst_ip),
		.peer_mac  (peer_mac),
		.init_seq  (init_seq_q),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_hdr   (front_hdr)
	);

	tsa_csum u_csum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_hdr    (front_hdr),
		.out_valid (csum_valid),
		.out_ready (csum_ready),
		.out_hdr   (csum_hdr),
		.ip_csum   (csum_ip),
		.tcp_sum   (csum_tcp)
	);

	assign csum_ready = !valid_s4 || out_ready;
	assign reply      = (csum_hdr.kind == KIND_REPLY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (csum_ready) begin
			valid_s4 <= csum_valid;
		end
	end

	// fields other than kind read zero when no reply is built
	always_ff @(posedge clk) begin
		if (csum_ready && csum_valid) begin
			kind_s4     <= csum_hdr.kind;
			dest_mac_s4 <= reply ? csum_hdr.peer_mac : '0;
			ip_src_s4   <= reply ? csum_hdr.my_ip : '0;
			ip_dst_s4   <= reply ? csum_hdr.peer_ip : '0;
			ip_csum_s4  <= reply ? csum_ip : '0;
			sport_s4    <= reply ? csum_hdr.dport : '0;
			dport_s4    <= reply ? csum_hdr.sport : '0;
			seq_s4      <= reply ? csum_hdr.init_seq : '0;
			ack_s4      <= reply ? csum_hdr.ack : '0;
			flags_s4    <= reply ? FLAGS_REPLY : '0;
			tcp_csum_s4 <= reply ? csum_fold(csum_tcp) : '0;
		end
	end

	assign out_valid      = valid_s4;
	assign kind           = kind_s4;
	assign dest_mac       = dest_mac_s4;
	assign reply_ip_src   = ip_src_s4;
	assign reply_ip_dst   = ip_dst_s4;
	assign ip_checksum    = ip_csum_s4;
	assign reply_src_port = sport_s4;
	assign reply_dst_port = dport_s4;
	assign reply_seq      = seq_s4;
	assign reply_ack      = ack_s4;
	assign reply_flags    = flags_s4;
	assign tcp_checksum   = tcp_csum_s4;

endmodule
